// File: hw/rtl/cds_pkg.sv
`default_nettype none

package cds_pkg;

  // sizes
  localparam int CHANNELS   = 32;
  localparam int DEVICES    = 32;
  localparam int LIST_SLOTS = 32;

  // fixed field widths
  localparam int CH_W    = 5;
  localparam int DEV_W   = 5;
  localparam int SLOT_W  = 5;
  localparam int LCH_W   = 6;
  localparam int TIME_W  = 16;
  localparam int COLOR_W = 3;
  localparam int COUNT_W = 8;
  localparam int ADDR_W  = DEV_W + SLOT_W;
  localparam int MEM_DEPTH = DEVICES * LIST_SLOTS;

  // request codes
  localparam logic [1:0] REQ_CHAN  = 2'd0;
  localparam logic [1:0] REQ_LIST  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // light colors
  localparam logic [COLOR_W-1:0] COL_OFF          = 3'd0;
  localparam logic [COLOR_W-1:0] COL_GREEN        = 3'd1;
  localparam logic [COLOR_W-1:0] COL_GREEN_BLINK  = 3'd2;
  localparam logic [COLOR_W-1:0] COL_YELLOW       = 3'd3;
  localparam logic [COLOR_W-1:0] COL_YELLOW_BLINK = 3'd4;
  localparam logic [COLOR_W-1:0] COL_RED          = 3'd5;
  localparam logic [COLOR_W-1:0] COL_RED_BLINK    = 3'd6;
  localparam logic [COLOR_W-1:0] COL_ALL_RED      = 3'd7;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_WALK  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/countdown_display_selector.sv
// countdown display selector: channel lights, per-device channel lists, display query
// a channel or list write completes at the accept edge; a query walks its list one slot a
//   cycle through the list memory read port, stopping at the first empty or out-of-range
//   entry or after the last slot, and done pulses in the cycle after the walk ends
// busy stays high during a walk, so no new request is taken until it ends; writes every cycle while idle
// reset: synchronous rst clears the channel table at once, then a clearing pass
//   zeroes every list memory entry while busy stays high; the receiver cannot stall
`default_nettype none

module countdown_display_selector
  import cds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         req_type,
  input  wire logic [CH_W-1:0]    channel_index,
  input  wire logic [COLOR_W-1:0] light_color,
  input  wire logic [TIME_W-1:0]  remaining_time,
  input  wire logic [DEV_W-1:0]   device,
  input  wire logic [SLOT_W-1:0]  slot,
  input  wire logic [LCH_W-1:0]   listed_channel,
  output logic                    done,
  output logic [COLOR_W-1:0]      show_color,
  output logic [COUNT_W-1:0]      show_count
);

  // control
  state_t              state;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [SLOT_W-1:0]   walk_slot;
  logic [DEV_W-1:0]    dev_reg;

  // channel table in flops, reset to off / zero
  logic [COLOR_W-1:0]  chan_color [CHANNELS];
  logic [TIME_W-1:0]   chan_time  [CHANNELS];

  // device list memory, one read and one write port
  logic [LCH_W-1:0]    device_lists [MEM_DEPTH];
  logic [LCH_W-1:0]    rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [LCH_W-1:0]    wr_data;
  logic                wr_en;

  // running selection
  logic [COLOR_W-1:0]  sel_color;
  logic [TIME_W-1:0]   sel_count;
  logic [TIME_W-1:0]   max_green;
  logic [TIME_W-1:0]   max_yellow;
  logic [TIME_W-1:0]   min_red;

  logic                accept;
  logic                dev_ok;
  logic                chan_ok;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign dev_ok  = 7'(device) < 7'(DEVICES);
  assign chan_ok = 7'(channel_index) < 7'(CHANNELS);

  // memory port muxing: clearing pass owns the write port after reset
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {device, slot};
    wr_data = listed_channel;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (accept && req_type == REQ_LIST && dev_ok) begin
      wr_en   = 1'b1;
    end
  end

  // slot 0 is fetched at accept, later slots one ahead of the walk
  always_comb begin
    if (state == S_WALK) begin
      rd_addr = {dev_reg, walk_slot + SLOT_W'(1)};
    end else begin
      rd_addr = {device, SLOT_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      device_lists[wr_addr] <= wr_data;
    end
    rd_data <= device_lists[rd_addr];
  end

  // one walk step: look up the listed channel and fold it into the selection
  logic                ent_valid;
  logic [CH_W-1:0]     ent_ch;
  logic [COLOR_W-1:0]  c;
  logic [TIME_W-1:0]   t;
  logic [TIME_W-1:0]   min_base;
  logic                green_take;
  logic                yellow_take;
  logic                red_take;
  logic                last_slot;
  logic [COLOR_W-1:0]  upd_color;
  logic [TIME_W-1:0]   upd_count;
  logic [TIME_W-1:0]   upd_green;
  logic [TIME_W-1:0]   upd_yellow;
  logic [TIME_W-1:0]   upd_red;

  always_comb begin
    ent_valid = (rd_data != '0) && (7'(rd_data) <= 7'(CHANNELS));
    ent_ch    = CH_W'(rd_data - LCH_W'(1));
    c         = chan_color[ent_ch];
    t         = chan_time[ent_ch];
    // red search starts from the first listed channel's countdown
    min_base  = (walk_slot == '0) ? t : min_red;
    last_slot = (walk_slot == SLOT_W'(LIST_SLOTS - 1));

    green_take  = (c inside {COL_GREEN, COL_GREEN_BLINK}) && (t > max_green);
    yellow_take = !green_take && (max_green == '0) &&
                  (c inside {COL_YELLOW, COL_YELLOW_BLINK}) && (t > max_yellow);
    red_take    = !green_take && !yellow_take && (max_green == '0) &&
                  (max_yellow == '0) &&
                  (c inside {COL_RED, COL_RED_BLINK, COL_ALL_RED}) && (t <= min_base);

    upd_color  = sel_color;
    upd_count  = sel_count;
    upd_green  = max_green;
    upd_yellow = max_yellow;
    upd_red    = min_red;
    if (ent_valid) begin
      upd_red = min_base;
      if (green_take) begin
        upd_green = t;
        upd_count = t;
        upd_color = c;
      end else if (yellow_take) begin
        upd_yellow = t;
        upd_count  = t;
        upd_color  = c;
      end else if (red_take) begin
        upd_red   = t;
        upd_count = t;
        // all red is shown as plain red
        upd_color = (c == COL_ALL_RED) ? COL_RED : c;
      end
    end
  end

  // channel table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_color[i] <= COL_OFF;
        chan_time[i]  <= '0;
      end
    end else if (accept && req_type == REQ_CHAN && chan_ok) begin
      chan_color[channel_index] <= light_color;
      chan_time[channel_index]  <= remaining_time;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && req_type == REQ_QUERY) begin
            if (dev_ok) begin
              state <= S_WALK;
            end else begin
              // unknown device shows off
              done <= 1'b1;
            end
          end
        end
        S_WALK: begin
          if (!ent_valid || last_slot) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // selection datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      walk_slot  <= '0;
      dev_reg    <= device;
      sel_color  <= COL_OFF;
      sel_count  <= '0;
      max_green  <= '0;
      max_yellow <= '0;
      min_red    <= '0;
      if (accept && req_type == REQ_QUERY) begin
        show_color <= COL_OFF;
        show_count <= '0;
      end
    end else if (state == S_WALK) begin
      walk_slot  <= walk_slot + SLOT_W'(1);
      sel_color  <= upd_color;
      sel_count  <= upd_count;
      max_green  <= upd_green;
      max_yellow <= upd_yellow;
      min_red    <= upd_red;
      if (!ent_valid || last_slot) begin
        show_color <= upd_color;
        // saturate the countdown at 255
        show_count <= (upd_count[TIME_W-1:COUNT_W] != '0) ? '1 : upd_count[COUNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
